/* design/joint_keyframe_blend_table_macros.svh */
// assertion macros for the joint keyframe blend table
`ifndef JOINT_KEYFRAME_BLEND_TABLE_MACROS_SVH
`define JOINT_KEYFRAME_BLEND_TABLE_MACROS_SVH

// condition implies consequence in the same cycle
`define JKBT_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define JKBT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

/* design/jkbt_pkg.sv */
// shared types and constants of the joint keyframe blend table
package jkbt_pkg;

  localparam int POSE_N = 8;
  localparam int COMP_W = 32;
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_FINAL  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_FULL    = 1'b1;

  typedef struct packed {
    logic                     go;
    logic signed [COMP_W-1:0] a;
    logic signed [COMP_W-1:0] b;
    logic [FRAC_W-1:0]        f;
  } blend_req_t;

endpackage

/* design/jkbt_frac.sv */
// ratio unit: (t - t0) / (t1 - t0) as a Q1.16 fraction, one quotient bit per cycle
module jkbt_frac #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [TIME_BITS-1:0]          t,
  input  logic [TIME_BITS-1:0]          t0,
  input  logic [TIME_BITS-1:0]          t1,
  output logic                          done,
  output logic [jkbt_pkg::FRAC_W-1:0]   f
);
  import jkbt_pkg::*;

  logic [TIME_BITS-1:0] num;
  logic [TIME_BITS-1:0] den_in;
  logic [TIME_BITS:0]   rem;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS-1:0] den;
  logic [15:0]          q;
  logic [3:0]           cnt;
  logic                 run;
  logic                 take;

  assign num    = t - t0;
  assign den_in = t1 - t0;
  assign rem_sh = {rem[TIME_BITS-1:0], 1'b0};
  assign take   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den_in == '0) begin
          f    <= '0;
          done <= 1'b1;
        end else if (num >= den_in) begin
          f    <= ONE_Q16;
          done <= 1'b1;
        end else begin
          rem <= {1'b0, num};
          den <= den_in;
          q   <= '0;
          cnt <= '0;
          run <= 1'b1;
        end
      end else if (run) begin
        rem <= take ? rem_sh - {1'b0, den} : rem_sh;
        q   <= {q[14:0], take};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
          f    <= {1'b0, q[14:0], take};
        end
      end
    end
  end

endmodule

/* design/jkbt_blend.sv */
// blend unit: a + round((b - a) * f / 65536), registered multiply, combinational add
module jkbt_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  jkbt_pkg::blend_req_t              req,
  output logic                              valid,
  output logic signed [jkbt_pkg::COMP_W-1:0] r
);
  import jkbt_pkg::*;

  logic signed [COMP_W:0]        diff;
  logic signed [FRAC_W:0]        fs;
  logic signed [COMP_W+FRAC_W:0] prod;
  logic signed [COMP_W+FRAC_W:0] rnd;
  logic signed [COMP_W+FRAC_W:0] sh;
  logic signed [COMP_W-1:0]      a_q;

  assign diff = {req.b[COMP_W-1], req.b} - {req.a[COMP_W-1], req.a};
  assign fs   = {1'b0, req.f};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= req.go;
    end
    if (req.go) begin
      a_q  <= req.a;
      prod <= diff * fs;
    end
  end

  // floor of the rounded product, halves go up
  assign rnd = prod + (COMP_W+FRAC_W+1)'(32768);
  assign sh  = rnd >>> 16;
  assign r   = a_q + sh[COMP_W-1:0];

endmodule

/* design/joint_keyframe_blend_table.sv */
// top level of the joint keyframe blend table
// Input stream (s_axis): one command word; tuser carries cmd (0 update, 1 finalize),
// tdata carries now_ticks, anim_id, key_time and the eight key pose components.
// Output stream (m_axis): exactly one word per command; tuser is the status
// (1 = update found no free slot), tdata is pose_time and the final pose,
// zero for updates.
// Commands are handled one at a time; s_axis_tready is high only while idle.
// Update: a slot search, a ratio division, then each pose component in turn
// through the shared blend unit. Finalize: division and blends for the final
// start pose, a minimum scan over the slots, then division and blends for the
// last occupied slot, if any. The divider and the blend multiplier are shared
// by all steps.
// A finished word sits in the output register; when the receiver stalls the
// block still takes one more command and works it through, then waits with
// that result until the held word is taken.
// Reset (rst, synchronous) empties every slot and zeroes the final pose and
// times; the pose memories are never used before a slot claim writes them.
module joint_keyframe_blend_table #(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_ticks, anim_id, key_time, key_pos_x..w, key_rot_x..w
  input  logic [351:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pose_time, pos_x..w, rot_x..w
  output logic [287:0] m_axis_tdata,
  // status
  output logic         m_axis_tuser
);
  import jkbt_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FRAC, S_FWAIT, S_RD, S_GO, S_WR, S_MIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {M_UPD, M_FIN1, M_FIN2} mode_t;

  state_t state;
  mode_t  mode;

  logic [ID_BITS-1:0]   ids      [SLOTS];
  logic [TIME_BITS-1:0] st_time  [SLOTS];
  logic [TIME_BITS-1:0] en_time  [SLOTS];
  logic [COMP_W-1:0]    start_mem[SLOTS*POSE_N];
  logic [COMP_W-1:0]    end_mem  [SLOTS*POSE_N];
  logic [COMP_W-1:0]    start_rd;
  logic [COMP_W-1:0]    end_rd;
  logic [COMP_W-1:0]    fin_start[POSE_N];
  logic [COMP_W-1:0]    fin_end  [POSE_N];
  logic [TIME_BITS-1:0] fst;
  logic [TIME_BITS-1:0] fet;

  logic                 cmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] kt_q;
  logic [COMP_W-1:0]    key_q[POSE_N];

  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] free_idx;
  logic              free_found;
  logic              occ_found;
  logic              fresh;
  logic              full_q;
  logic [2:0]        j;

  logic              free_now;
  logic [SLOT_W-1:0] free_sel;
  logic              last_idx;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;

  logic                 frac_start;
  logic [TIME_BITS-1:0] ft, ft0, ft1;
  logic                 frac_done;
  logic [FRAC_W-1:0]    frac_f;

  blend_req_t               breq;
  logic                     bl_valid;
  logic signed [COMP_W-1:0] bl_r;

  logic s_acc;

  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign free_now = (ids[idx] == '0);
  assign free_sel = free_now ? idx : free_idx;
  assign last_idx = (idx == SLOT_W'(SLOTS - 1));
  assign addr     = {slot, j};
  assign mem_we   = (state == S_WR) && (mode == M_UPD);

  assign frac_start = (state == S_FRAC);

  always_comb begin
    case (mode)
      M_UPD: begin
        ft  = now_q;
        ft0 = fresh ? '0 : st_time[slot];
        ft1 = fresh ? '0 : en_time[slot];
      end
      M_FIN1: begin
        ft  = now_q;
        ft0 = fst;
        ft1 = fet;
      end
      M_FIN2: begin
        ft  = fet;
        ft0 = st_time[slot];
        ft1 = en_time[slot];
      end
      default: begin
        ft  = '0;
        ft0 = '0;
        ft1 = '0;
      end
    endcase
  end

  always_comb begin
    breq.go = (state == S_GO);
    breq.f  = frac_f;
    if (mode == M_FIN1) begin
      breq.a = fin_start[j];
      breq.b = fin_end[j];
    end else if (mode == M_UPD && fresh) begin
      breq.a = '0;
      breq.b = '0;
    end else begin
      breq.a = start_rd;
      breq.b = end_rd;
    end
  end

  jkbt_frac #(.TIME_BITS(TIME_BITS)) u_frac (
    .clk   (clk),
    .rst   (rst),
    .start (frac_start),
    .t     (ft),
    .t0    (ft0),
    .t1    (ft1),
    .done  (frac_done),
    .f     (frac_f)
  );

  jkbt_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .req   (breq),
    .valid (bl_valid),
    .r     (bl_r)
  );

  // slot pose memories
  always_ff @(posedge clk) begin
    start_rd <= start_mem[addr];
    end_rd   <= end_mem[addr];
    if (mem_we) begin
      start_mem[addr] <= bl_r;
      end_mem[addr]   <= key_q[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= M_UPD;
      m_axis_tvalid <= 1'b0;
      fst           <= '0;
      fet           <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        ids[s]     <= '0;
        st_time[s] <= '0;
        en_time[s] <= '0;
      end
      for (int k = 0; k < POSE_N; k++) begin
        fin_start[k] <= '0;
        fin_end[k]   <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            cmd_q      <= s_axis_tuser;
            now_q      <= TIME_BITS'(s_axis_tdata[31:0]);
            id_q       <= ID_BITS'(s_axis_tdata[63:32]);
            kt_q       <= TIME_BITS'(s_axis_tdata[95:64]);
            for (int k = 0; k < POSE_N; k++) begin
              key_q[k] <= s_axis_tdata[96 + 32*k +: 32];
            end
            idx        <= '0;
            free_found <= 1'b0;
            full_q     <= ST_OK;
            if (s_axis_tuser == CMD_UPDATE) begin
              mode  <= M_UPD;
              state <= S_SCAN;
            end else begin
              mode  <= M_FIN1;
              state <= S_FRAC;
            end
          end
        end
        S_SCAN: begin
          if (free_now) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (!free_now && ids[idx] == id_q) begin
            slot  <= idx;
            fresh <= 1'b0;
            state <= S_FRAC;
          end else if (last_idx) begin
            if (free_found || free_now) begin
              slot          <= free_sel;
              ids[free_sel] <= id_q;
              fresh         <= 1'b1;
              state         <= S_FRAC;
            end else begin
              full_q <= ST_FULL;
              state  <= S_OUT;
            end
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_FRAC: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (frac_done) begin
            j     <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_GO;
        end
        S_GO: begin
          state <= S_WR;
        end
        S_WR: begin
          if (mode == M_FIN1) begin
            fin_start[j] <= bl_r;
            fin_end[j]   <= '0;
          end else if (mode == M_FIN2) begin
            fin_end[j] <= bl_r;
          end
          j <= j + 3'd1;
          if (j == 3'd7) begin
            case (mode)
              M_UPD: begin
                st_time[slot] <= now_q;
                en_time[slot] <= kt_q;
                state         <= S_OUT;
              end
              M_FIN1: begin
                fst       <= now_q;
                fet       <= now_q;
                idx       <= '0;
                occ_found <= 1'b0;
                state     <= S_MIN;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end else begin
            state <= S_RD;
          end
        end
        S_MIN: begin
          // least of now and the end times of occupied slots, and the last occupied slot
          if (ids[idx] != '0) begin
            if (en_time[idx] < fet) begin
              fet <= en_time[idx];
            end
            occ_found <= 1'b1;
            slot      <= idx;
          end
          if (last_idx) begin
            if (occ_found || ids[idx] != '0) begin
              mode  <= M_FIN2;
              state <= S_FRAC;
            end else begin
              state <= S_OUT;
            end
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= full_q;
            if (cmd_q == CMD_FINAL) begin
              m_axis_tdata[31:0] <= 32'(fet);
              for (int k = 0; k < POSE_N; k++) begin
                m_axis_tdata[32 + 32*k +: 32] <= fin_end[k];
              end
            end else begin
              m_axis_tdata <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "joint_keyframe_blend_table_macros.svh"

  `JKBT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_acc, !s_axis_tready, "ready after accept")
  `JKBT_ASSERT_NOW(a_frac_range, clk, rst, state == S_RD, frac_f <= ONE_Q16, "fraction above one")
  `JKBT_ASSERT_NOW(a_full_zero, clk, rst, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata == '0, "full word carries data")
  `JKBT_ASSERT_NOW(a_blend_ready, clk, rst, state == S_WR, bl_valid, "blend result missing")

endmodule
